[rtl/vct_pkg.sv]
// Package for the Vietnamese charset transcoder: letter tables, lookup and
// spelling functions, and shared types. Used by the top level and the testbench.
// No dependencies.
package vct_pkg;

  localparam int LETTER_COUNT = 134;
  localparam int IDX_W        = 8;

  // Encoding register codes
  localparam logic [2:0] ENC_UTF8   = 3'd0;
  localparam logic [2:0] ENC_VNI    = 3'd1;
  localparam logic [2:0] ENC_VPS    = 3'd2;
  localparam logic [2:0] ENC_VISCII = 3'd3;
  localparam logic [2:0] ENC_TCVN3  = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_SOURCE = 2'd0;
  localparam logic [1:0] REG_TARGET = 2'd1;

  typedef enum logic [1:0] {
    SYM_NONE,
    SYM_RAW,
    SYM_LETTER
  } sym_kind_e;

  // One decoded beat: up to two symbols, error and end flags
  typedef struct packed {
    sym_kind_e  kind0;
    logic [7:0] val0;
    sym_kind_e  kind1;
    logic [7:0] val1;
    logic       err;
    logic       eos;
  } item_t;

  // Spelling of one symbol in the target encoding, by[0] goes out first
  typedef struct packed {
    logic [1:0]      len;
    logic [2:0][7:0] by;
  } spell_t;

  localparam logic [23:0] ROM_UTF8 [LETTER_COUNT] = '{
    24'hC380, 24'hC381, 24'hC382, 24'hC383, 24'hC388, 24'hC389, 24'hC38A, 24'hC38C,
    24'hC38D, 24'hC392, 24'hC393, 24'hC394, 24'hC395, 24'hC399, 24'hC39A, 24'hC39D,
    24'hC3A0, 24'hC3A1, 24'hC3A2, 24'hC3A3, 24'hC3A8, 24'hC3A9, 24'hC3AA, 24'hC3AC,
    24'hC3AD, 24'hC3B2, 24'hC3B3, 24'hC3B4, 24'hC3B5, 24'hC3B9, 24'hC3BA, 24'hC3BD,
    24'hC482, 24'hC483, 24'hC490, 24'hC491, 24'hC4A8, 24'hC4A9, 24'hC5A8, 24'hC5A9,
    24'hC6A0, 24'hC6A1, 24'hC6AF, 24'hC6B0,
    24'hE1BAA0, 24'hE1BAA1, 24'hE1BAA2, 24'hE1BAA3, 24'hE1BAA4, 24'hE1BAA5, 24'hE1BAA6,
    24'hE1BAA7, 24'hE1BAA8, 24'hE1BAA9, 24'hE1BAAA, 24'hE1BAAB, 24'hE1BAAC, 24'hE1BAAD,
    24'hE1BAAE, 24'hE1BAAF, 24'hE1BAB0, 24'hE1BAB1, 24'hE1BAB2, 24'hE1BAB3, 24'hE1BAB4,
    24'hE1BAB5, 24'hE1BAB6, 24'hE1BAB7, 24'hE1BAB8, 24'hE1BAB9, 24'hE1BABA, 24'hE1BABB,
    24'hE1BABC, 24'hE1BABD, 24'hE1BABE, 24'hE1BABF,
    24'hE1BB80, 24'hE1BB81, 24'hE1BB82, 24'hE1BB83, 24'hE1BB84, 24'hE1BB85, 24'hE1BB86,
    24'hE1BB87, 24'hE1BB88, 24'hE1BB89, 24'hE1BB8A, 24'hE1BB8B, 24'hE1BB8C, 24'hE1BB8D,
    24'hE1BB8E, 24'hE1BB8F, 24'hE1BB90, 24'hE1BB91, 24'hE1BB92, 24'hE1BB93, 24'hE1BB94,
    24'hE1BB95, 24'hE1BB96, 24'hE1BB97, 24'hE1BB98, 24'hE1BB99, 24'hE1BB9A, 24'hE1BB9B,
    24'hE1BB9C, 24'hE1BB9D, 24'hE1BB9E, 24'hE1BB9F, 24'hE1BBA0, 24'hE1BBA1, 24'hE1BBA2,
    24'hE1BBA3, 24'hE1BBA4, 24'hE1BBA5, 24'hE1BBA6, 24'hE1BBA7, 24'hE1BBA8, 24'hE1BBA9,
    24'hE1BBAA, 24'hE1BBAB, 24'hE1BBAC, 24'hE1BBAD, 24'hE1BBAE, 24'hE1BBAF, 24'hE1BBB0,
    24'hE1BBB1, 24'hE1BBB2, 24'hE1BBB3, 24'hE1BBB4, 24'hE1BBB5, 24'hE1BBB6, 24'hE1BBB7,
    24'hE1BBB8, 24'hE1BBB9
  };

  localparam logic [15:0] ROM_VNI [LETTER_COUNT] = '{
    16'h41D8, 16'h41D9, 16'h41C2, 16'h41D5, 16'h45D8, 16'h45D9, 16'h45C2, 16'h00CC,
    16'h00CD, 16'h4FD8, 16'h4FD9, 16'h4FC2, 16'h4FD5, 16'h55D8, 16'h55D9, 16'h59D9,
    16'h61F8, 16'h61F9, 16'h61E2, 16'h61F5, 16'h65F8, 16'h65F9, 16'h65E2, 16'h00EC,
    16'h00ED, 16'h6FF8, 16'h6FF9, 16'h6FE2, 16'h6FF5, 16'h75F8, 16'h75F9, 16'h79F9,
    16'h41CA, 16'h61EA, 16'h00D1, 16'h00F1, 16'h00D3, 16'h00F3, 16'h55D5, 16'h75F5,
    16'h00D4, 16'h00F4, 16'h00D6, 16'h00F6, 16'h41CF, 16'h61EF, 16'h41DB, 16'h61FB,
    16'h41C1, 16'h61E1, 16'h41C0, 16'h61E0, 16'h41C5, 16'h61E5, 16'h41C3, 16'h61E3,
    16'h41C4, 16'h61E4, 16'h41C9, 16'h61E9, 16'h41C8, 16'h61E8, 16'h41DA, 16'h61FA,
    16'h41DC, 16'h61FC, 16'h41CB, 16'h61EB, 16'h45CF, 16'h65EF, 16'h45DB, 16'h65FB,
    16'h45D5, 16'h65F5, 16'h45C1, 16'h65E1, 16'h45C0, 16'h65E0, 16'h45C5, 16'h65E5,
    16'h45C3, 16'h65E3, 16'h45C4, 16'h65E4, 16'h00C6, 16'h00E6, 16'h00D2, 16'h00F2,
    16'h4FCF, 16'h6FEF, 16'h4FDB, 16'h6FFB, 16'h4FC1, 16'h6FE1, 16'h4FC0, 16'h6FE0,
    16'h4FC5, 16'h6FE5, 16'h4FC3, 16'h6FE3, 16'h4FC4, 16'h6FE4, 16'hD4D9, 16'hF4F9,
    16'hD4D8, 16'hF4F8, 16'hD4DB, 16'hF4FB, 16'hD4D5, 16'hF4F5, 16'hD4CF, 16'hF4EF,
    16'h55CF, 16'h75EF, 16'h55DB, 16'h75FB, 16'hD6D9, 16'hF6F9, 16'hD6D8, 16'hF6F8,
    16'hD6DB, 16'hF6FB, 16'hD6D5, 16'hF6F5, 16'hD6CF, 16'hF6EF, 16'h59D8, 16'h79F8,
    16'h00CE, 16'h00EE, 16'h59DB, 16'h79FB, 16'h59D5, 16'h79F5
  };

  localparam logic [7:0] ROM_VPS [LETTER_COUNT] = '{
    8'h80, 8'hC1, 8'hC2, 8'h82, 8'hD7, 8'hC9, 8'hCA, 8'hB5, 8'hB4, 8'hBC, 8'hB9, 8'hD4,
    8'hBE, 8'hA8, 8'hDA, 8'hDD, 8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE8, 8'hE9, 8'hEA, 8'hEC,
    8'hED, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF9, 8'hFA, 8'h9A, 8'h88, 8'hE6, 8'hF1, 8'hC7,
    8'hB8, 8'hEF, 8'hAC, 8'hDB, 8'hF7, 8'hD6, 8'hD0, 8'hDC, 8'h02, 8'hE5, 8'h81, 8'hE4,
    8'h83, 8'hC3, 8'h84, 8'hC0, 8'h85, 8'hC4, 8'h1C, 8'hC5, 8'h03, 8'hC6, 8'h8D, 8'hA1,
    8'h8E, 8'hA2, 8'h8F, 8'hA3, 8'hF0, 8'hA4, 8'h04, 8'hA5, 8'h05, 8'hCB, 8'hDE, 8'hC8,
    8'hFE, 8'hEB, 8'h90, 8'h89, 8'h93, 8'h8A, 8'h94, 8'h8B, 8'h95, 8'hCD, 8'h06, 8'h8C,
    8'hB7, 8'hCC, 8'h10, 8'hCE, 8'h11, 8'h86, 8'hBD, 8'hD5, 8'h96, 8'hD3, 8'h97, 8'hD2,
    8'h98, 8'hB0, 8'h99, 8'h87, 8'h12, 8'hB6, 8'h9D, 8'hA7, 8'h9E, 8'hA9, 8'h9F, 8'hAA,
    8'hA6, 8'hAB, 8'h13, 8'hAE, 8'h14, 8'hF8, 8'hD1, 8'hFB, 8'hAD, 8'hD9, 8'hAF, 8'hD8,
    8'hB1, 8'hBA, 8'h1D, 8'hBB, 8'h15, 8'hBF, 8'hB2, 8'hFF, 8'h19, 8'h9C, 8'hFD, 8'h9B,
    8'hB3, 8'hCF
  };

  localparam logic [7:0] ROM_VISCII [LETTER_COUNT] = '{
    8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC8, 8'hC9, 8'hCA, 8'hCC, 8'hCD, 8'hD2, 8'hD3, 8'hD4,
    8'hA0, 8'hD9, 8'hDA, 8'hDD, 8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE8, 8'hE9, 8'hEA, 8'hEC,
    8'hED, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF9, 8'hFA, 8'hFD, 8'hC5, 8'hE5, 8'hD0, 8'hF0,
    8'hCE, 8'hEE, 8'h9D, 8'hFB, 8'hB4, 8'hBD, 8'hBF, 8'hDF, 8'h80, 8'hD5, 8'hC4, 8'hE4,
    8'h84, 8'hA4, 8'h85, 8'hA5, 8'h86, 8'hA6, 8'h06, 8'hE7, 8'h87, 8'hA7, 8'h81, 8'hA1,
    8'h82, 8'hA2, 8'h02, 8'hC6, 8'h05, 8'hC7, 8'h83, 8'hA3, 8'h89, 8'hA9, 8'hCB, 8'hEB,
    8'h88, 8'hA8, 8'h8A, 8'hAA, 8'h8B, 8'hAB, 8'h8C, 8'hAC, 8'h8D, 8'hAD, 8'h8E, 8'hAE,
    8'h9B, 8'hEF, 8'h98, 8'hB8, 8'h9A, 8'hF7, 8'h99, 8'hF6, 8'h8F, 8'hAF, 8'h90, 8'hB0,
    8'h91, 8'hB1, 8'h92, 8'hB2, 8'h93, 8'hB5, 8'h95, 8'hBE, 8'h96, 8'hB6, 8'h97, 8'hB7,
    8'hB3, 8'hDE, 8'h94, 8'hFE, 8'h9E, 8'hF8, 8'h9C, 8'hFC, 8'hBA, 8'hD1, 8'hBB, 8'hD7,
    8'hBC, 8'hD8, 8'hFF, 8'hE6, 8'hB9, 8'hF1, 8'h9F, 8'hCF, 8'h1E, 8'hDC, 8'h14, 8'hD6,
    8'h19, 8'hDB
  };

  localparam logic [15:0] ROM_TCVN3 [LETTER_COUNT] = '{
    16'h41B5, 16'h41B8, 16'h00A2, 16'h41B7, 16'h45CC, 16'h45D0, 16'h00A3, 16'h49D7,
    16'h49DD, 16'h4FDF, 16'h4FE3, 16'h00A4, 16'h4FE2, 16'h55EF, 16'h55F3, 16'h59FD,
    16'h00B5, 16'h00B8, 16'h00A9, 16'h00B7, 16'h00CC, 16'h00D0, 16'h00AA, 16'h00D7,
    16'h00DD, 16'h00DF, 16'h00E3, 16'h00AB, 16'h00E2, 16'h00EF, 16'h00F3, 16'h00FD,
    16'h00A1, 16'h00A8, 16'h00A7, 16'h00AE, 16'h49DC, 16'h00DC, 16'h55F2, 16'h00F2,
    16'h00A5, 16'h00AC, 16'h00A6, 16'h00AD, 16'h41B9, 16'h00B9, 16'h41B6, 16'h00B6,
    16'hA2CA, 16'h00CA, 16'hA2C7, 16'h00C7, 16'hA2C8, 16'h00C8, 16'hA2C9, 16'h00C9,
    16'hA2CB, 16'h00CB, 16'hA1BE, 16'h00BE, 16'hA1BB, 16'h00BB, 16'hA1BC, 16'h00BC,
    16'hA1BD, 16'h00BD, 16'hA1C6, 16'h00C6, 16'h45D1, 16'h00D1, 16'h45CE, 16'h00CE,
    16'h45CF, 16'h00CF, 16'hA3D5, 16'h00D5, 16'hA3D2, 16'h00D2, 16'hA3D3, 16'h00D3,
    16'hA3D4, 16'h00D4, 16'hA3D6, 16'h00D6, 16'h49D8, 16'h00D8, 16'h49DE, 16'h00DE,
    16'h4FE4, 16'h00E4, 16'h4FE1, 16'h00E1, 16'hA4E8, 16'h00E8, 16'hA4E5, 16'h00E5,
    16'hA4E6, 16'h00E6, 16'hA4E7, 16'h00E7, 16'hA4E9, 16'h00E9, 16'hA5ED, 16'h00ED,
    16'hA5EA, 16'h00EA, 16'hA5EB, 16'h00EB, 16'hA5EC, 16'h00EC, 16'hA5EE, 16'h00EE,
    16'h55F4, 16'h00F4, 16'h55F1, 16'h00F1, 16'hA6F8, 16'h00F8, 16'hA6F5, 16'h00F5,
    16'hA6F6, 16'h00F6, 16'hA6F7, 16'h00F7, 16'hA6F9, 16'h00F9, 16'h59FA, 16'h00FA,
    16'h59FE, 16'h00FE, 16'h59FB, 16'h00FB, 16'h59FC, 16'h00FC
  };

  // Lookups return {hit, index}; the highest matching index wins
  function automatic logic [IDX_W:0] find_utf8(logic [23:0] v);
    logic [IDX_W:0] r;
    r = '0;
    for (int i = 0; i < LETTER_COUNT; i++) begin
      if (ROM_UTF8[i] == v) r = {1'b1, IDX_W'(i)};
    end
    return r;
  endfunction

  function automatic logic [15:0] legacy_entry(logic tcvn, int i);
    return tcvn ? ROM_TCVN3[i] : ROM_VNI[i];
  endfunction

  // Two-byte entries only
  function automatic logic [IDX_W:0] find_pair(logic tcvn, logic [15:0] v);
    logic [IDX_W:0] r;
    logic [15:0]    e;
    r = '0;
    for (int i = 0; i < LETTER_COUNT; i++) begin
      e = legacy_entry(tcvn, i);
      if (e[15:8] != 8'h00 && e == v) r = {1'b1, IDX_W'(i)};
    end
    return r;
  endfunction

  function automatic logic [IDX_W:0] find_single16(logic tcvn, logic [7:0] b);
    logic [IDX_W:0] r;
    r = '0;
    for (int i = 0; i < LETTER_COUNT; i++) begin
      if (legacy_entry(tcvn, i) == {8'h00, b}) r = {1'b1, IDX_W'(i)};
    end
    return r;
  endfunction

  function automatic logic [IDX_W:0] find_single8(logic viscii, logic [7:0] b);
    logic [IDX_W:0] r;
    r = '0;
    for (int i = 0; i < LETTER_COUNT; i++) begin
      if ((viscii ? ROM_VISCII[i] : ROM_VPS[i]) == b) r = {1'b1, IDX_W'(i)};
    end
    return r;
  endfunction

  // Target spelling of one symbol
  function automatic spell_t make_spell(sym_kind_e kind, logic [7:0] val, logic [2:0] tgt);
    spell_t      s;
    logic [23:0] u;
    logic [15:0] l;
    s = '0;
    u = ROM_UTF8[val];
    l = (tgt == ENC_TCVN3) ? ROM_TCVN3[val] : ROM_VNI[val];
    case (kind)
      SYM_RAW: begin
        s.len   = 2'd1;
        s.by[0] = val;
      end
      SYM_LETTER: begin
        unique case (tgt)
          ENC_UTF8: begin
            if (u[23:16] != 8'h00) begin
              s.len = 2'd3;
              s.by  = {u[7:0], u[15:8], u[23:16]};
            end else begin
              s.len = 2'd2;
              s.by  = {8'h00, u[7:0], u[15:8]};
            end
          end
          ENC_VNI, ENC_TCVN3: begin
            if (l[15:8] != 8'h00) begin
              s.len = 2'd2;
              s.by  = {8'h00, l[7:0], l[15:8]};
            end else begin
              s.len   = 2'd1;
              s.by[0] = l[7:0];
            end
          end
          ENC_VPS: begin
            s.len   = 2'd1;
            s.by[0] = ROM_VPS[val];
          end
          default: begin
            s.len   = 2'd1;
            s.by[0] = ROM_VISCII[val];
          end
        endcase
      end
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

[rtl/vietnamese_charset_transcoder_unit.sv]
// The stages are the decode register, the registered spelling ROM read and the emitter.
// One input beat per cycle enters the decode stage while in_stall_o is low; the output
// emits one beat per cycle while out_stall_i is low, and an input byte yields 0 to 6
// output bytes (up to 3 per letter in UTF-8), serialized by the emitter.
// Reset (rst_ni, async, low) clears config, held bytes, discard flag and all stage valids.
// Top level of the transcoder; uses vct_pkg for tables, lookups and types.
module vietnamese_charset_transcoder_unit
  import vct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [2:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_end_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_byte_valid_o,
  output logic       out_last_of_run_o,
  output logic       out_stream_done_o,
  output logic       out_error_flag_o
);

  logic [2:0]  src_q, tgt_q;
  logic [15:0] held_q, held_d;
  logic [1:0]  hc_q, hc_d;
  logic        disc_q, disc_d;

  item_t       itm;
  logic        itm_has;
  logic        accept;

  logic        a_vld_q, b_vld_q, e_vld_q;
  item_t       a_q;
  spell_t      b_sp0_q, b_sp1_q;
  logic        b_err_q, b_eos_q;
  logic [7:0]  e_byte_q [6];
  logic [2:0]  e_cnt_q, e_ptr_q;
  logic        e_mark_q, e_err_q, e_eos_q;

  logic        e_last, e_free, b_adv, b_free, a_adv, a_free, out_take;

  logic [IDX_W:0] u2, u3, pr, sh, sb, s8;
  logic [7:0]  h;
  logic        src_tcvn;

  logic [7:0]  lst [6];
  logic [2:0]  tot, ld_cnt;
  logic        ld_mark;

  // Handshake chain
  assign out_take   = e_vld_q && !out_stall_i;
  assign e_last     = (e_ptr_q == e_cnt_q - 3'd1);
  assign e_free     = !e_vld_q || (out_take && e_last);
  assign b_adv      = b_vld_q && e_free;
  assign b_free     = !b_vld_q || b_adv;
  assign a_adv      = a_vld_q && b_free;
  assign a_free     = !a_vld_q || a_adv;
  assign in_stall_o = !a_free;
  assign accept     = in_valid_i && a_free;

  // Table lookups against the held and incoming bytes
  assign h        = held_q[7:0];
  assign src_tcvn = (src_q == ENC_TCVN3);
  assign u2 = find_utf8({8'h00, h, in_byte_i});
  assign u3 = find_utf8({held_q, in_byte_i});
  assign pr = find_pair(src_tcvn, {h, in_byte_i});
  assign sh = find_single16(src_tcvn, h);
  assign sb = find_single16(src_tcvn, in_byte_i);
  assign s8 = find_single8(src_q == ENC_VISCII, in_byte_i);

  // Decode: next held state and the beat's symbols
  always_comb begin
    held_d = held_q;
    hc_d   = hc_q;
    disc_d = disc_q;
    itm    = '0;
    itm.kind0 = SYM_NONE;
    itm.kind1 = SYM_NONE;
    itm.eos   = in_end_of_stream_i;
    if (disc_q) begin
      // drop until end
    end else if (src_q == tgt_q || src_q > ENC_TCVN3 || tgt_q > ENC_TCVN3) begin
      itm.kind0 = SYM_RAW;
      itm.val0  = in_byte_i;
    end else if (src_q == ENC_UTF8) begin
      if (hc_q == 2'd0) begin
        if (!in_byte_i[7]) begin
          itm.kind0 = SYM_RAW;
          itm.val0  = in_byte_i;
        end else begin
          held_d = {8'h00, in_byte_i};
          hc_d   = 2'd1;
        end
      end else if (hc_q == 2'd1) begin
        if (u2[IDX_W]) begin
          itm.kind0 = SYM_LETTER;
          itm.val0  = u2[IDX_W-1:0];
          held_d    = '0;
          hc_d      = 2'd0;
        end else begin
          held_d = {h, in_byte_i};
          hc_d   = 2'd2;
        end
      end else begin
        if (u3[IDX_W]) begin
          itm.kind0 = SYM_LETTER;
          itm.val0  = u3[IDX_W-1:0];
        end else begin
          itm.err = 1'b1;
        end
        held_d = '0;
        hc_d   = 2'd0;
      end
    end else if (src_q == ENC_VPS || src_q == ENC_VISCII) begin
      if (!in_byte_i[7]) begin
        itm.kind0 = SYM_RAW;
        itm.val0  = in_byte_i;
      end else if (s8[IDX_W]) begin
        itm.kind0 = SYM_LETTER;
        itm.val0  = s8[IDX_W-1:0];
      end else begin
        itm.err = 1'b1;
      end
    end else begin
      // VNI / TCVN3: longest match with one byte of lookahead
      if (hc_q == 2'd0) begin
        held_d = {8'h00, in_byte_i};
        hc_d   = 2'd1;
      end else if (pr[IDX_W]) begin
        itm.kind0 = SYM_LETTER;
        itm.val0  = pr[IDX_W-1:0];
        held_d    = '0;
        hc_d      = 2'd0;
      end else if (!h[7]) begin
        itm.kind0 = SYM_RAW;
        itm.val0  = h;
        held_d    = {8'h00, in_byte_i};
      end else if (sh[IDX_W]) begin
        itm.kind0 = SYM_LETTER;
        itm.val0  = sh[IDX_W-1:0];
        held_d    = {8'h00, in_byte_i};
      end else begin
        itm.err = 1'b1;
      end
      // flush the byte left held at end of text
      if (in_end_of_stream_i && !itm.err && hc_d != 2'd0) begin
        if (!in_byte_i[7]) begin
          itm.kind1 = SYM_RAW;
          itm.val1  = in_byte_i;
        end else if (sb[IDX_W]) begin
          itm.kind1 = SYM_LETTER;
          itm.val1  = sb[IDX_W-1:0];
        end
      end
    end
    if (itm.err) begin
      held_d = '0;
      hc_d   = 2'd0;
      disc_d = 1'b1;
    end
    if (in_end_of_stream_i) begin
      held_d = '0;
      hc_d   = 2'd0;
      disc_d = 1'b0;
    end
    itm_has = (itm.kind0 != SYM_NONE) || (itm.kind1 != SYM_NONE) || itm.err || itm.eos;
  end

  // Config and stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q  <= ENC_UTF8;
      tgt_q  <= ENC_UTF8;
      held_q <= '0;
      hc_q   <= 2'd0;
      disc_q <= 1'b0;
    end else if (cfg_we_i && (cfg_idx_i == REG_SOURCE || cfg_idx_i == REG_TARGET)) begin
      if (cfg_idx_i == REG_SOURCE) src_q <= cfg_wdata_i;
      else                         tgt_q <= cfg_wdata_i;
      held_q <= '0;
      hc_q   <= 2'd0;
      disc_q <= 1'b0;
    end else if (accept) begin
      held_q <= held_d;
      hc_q   <= hc_d;
      disc_q <= disc_d;
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else begin
      if (accept)     a_vld_q <= itm_has;
      else if (a_adv) a_vld_q <= 1'b0;
      if (b_free)     b_vld_q <= a_vld_q;
      if (e_free)     e_vld_q <= b_vld_q;
    end
  end

  // Decode stage register
  always_ff @(posedge clk_i) begin
    if (accept) a_q <= itm;
  end

  // Spelling ROM read, registered
  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_sp0_q <= make_spell(a_q.kind0, a_q.val0, tgt_q);
      b_sp1_q <= make_spell(a_q.kind1, a_q.val1, tgt_q);
      b_err_q <= a_q.err;
      b_eos_q <= a_q.eos;
    end
  end

  // Pack both spellings into one byte list
  always_comb begin
    for (int k = 0; k < 6; k++) lst[k] = 8'h00;
    for (int j = 0; j < 3; j++) begin
      if (2'(j) < b_sp0_q.len) lst[3'(j)] = b_sp0_q.by[j];
    end
    for (int j = 0; j < 3; j++) begin
      if (2'(j) < b_sp1_q.len) lst[3'(j) + {1'b0, b_sp0_q.len}] = b_sp1_q.by[j];
    end
    tot     = {1'b0, b_sp0_q.len} + {1'b0, b_sp1_q.len};
    ld_mark = (tot == 3'd0);
    ld_cnt  = ld_mark ? 3'd1 : tot;
  end

  // Emitter pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_ptr_q <= 3'd0;
    end else if (e_free) begin
      e_ptr_q <= 3'd0;
    end else if (out_take) begin
      e_ptr_q <= e_ptr_q + 3'd1;
    end
  end

  // Emitter payload
  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      for (int k = 0; k < 6; k++) e_byte_q[k] <= lst[k];
      e_cnt_q  <= ld_cnt;
      e_mark_q <= ld_mark;
      e_err_q  <= b_err_q;
      e_eos_q  <= b_eos_q;
    end
  end

  assign out_valid_o       = e_vld_q;
  assign out_byte_o        = e_mark_q ? 8'h00 : e_byte_q[e_ptr_q];
  assign out_byte_valid_o  = !e_mark_q;
  assign out_last_of_run_o = e_last;
  assign out_stream_done_o = e_last && e_eos_q;
  assign out_error_flag_o  = e_mark_q && e_err_q;

endmodule

[rtl/vct_checker.sv]
// Port-level checker for the transcoder, bound to the top level.
// Depends on nothing but the top level's ports.
module vct_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic [1:0] cfg_idx_i,
  input logic [2:0] cfg_wdata_i,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] in_byte_i,
  input logic       in_end_of_stream_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       out_byte_valid_o,
  input logic       out_last_of_run_o,
  input logic       out_stream_done_o,
  input logic       out_error_flag_o
);

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(out_last_of_run_o) && $stable(out_error_flag_o))
    else $error("stalled result beat changed");

  // Error beat carries no byte and ends its run
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_error_flag_o |-> !out_byte_valid_o && out_last_of_run_o)
    else $error("error beat malformed");

  // End of text closes a run
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stream_done_o |-> out_last_of_run_o)
    else $error("stream_done without last_of_run");

  // Markers carry a zero byte and are alone in their run
  a_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_byte_valid_o |-> out_byte_o == 8'h00 && out_last_of_run_o)
    else $error("marker beat malformed");

endmodule

bind vietnamese_charset_transcoder_unit vct_checker u_vct_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for vietnamese_charset_transcoder_unit: drives byte streams under random
// idling, predicts every output beat with a local transcoder model, checks in order.
// Depends on vct_pkg (encoding and register codes, letter tables) and the RTL top.
module tb_top;
  import vct_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       eos;
    logic       cfg;     // configuration write, not a byte
    logic [1:0] ridx;
    logic [2:0] rval;
  } stim_t;

  typedef struct {
    logic [7:0] data;
    logic       bval;
    logic       last;
    logic       done;
    logic       err;
  } beat_t;

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       cfg_we_i = 0;
  logic [1:0] cfg_idx_i = '0;
  logic [2:0] cfg_wdata_i = '0;
  logic       in_valid_i = 0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = '0;
  logic       in_end_of_stream_i = 0;
  logic       out_valid_o;
  logic       out_stall_i = 0;
  logic [7:0] out_byte_o;
  logic       out_byte_valid_o, out_last_of_run_o, out_stream_done_o, out_error_flag_o;

  vietnamese_charset_transcoder_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // Model state
  logic [2:0]  src_enc, tgt_enc;
  logic [15:0] held;
  int          held_n;
  logic        dropping;

  stim_t pending_q[$];
  beat_t expected_q[$];
  int    fails = 0;
  int    src_idle_pct = 0, snk_idle_pct = 0;
  bit    in_taken = 0;   // input beat accepted at the last rising edge

  beat_t step_out[$];

  function automatic int utf8_letter(logic [23:0] v);
    int hit = -1;
    for (int i = 0; i < LETTER_COUNT; i++) if (ROM_UTF8[i] == v) hit = i;
    return hit;
  endfunction

  function automatic logic [15:0] legacy_code(logic [2:0] enc, int i);
    return (enc == ENC_VNI) ? ROM_VNI[i] : ROM_TCVN3[i];
  endfunction

  function automatic int legacy_pair(logic [15:0] v);
    int hit = -1;
    logic [15:0] e;
    for (int i = 0; i < LETTER_COUNT; i++) begin
      e = legacy_code(src_enc, i);
      if (e > 16'hFF && e == v) hit = i;
    end
    return hit;
  endfunction

  function automatic int legacy_single(logic [7:0] b);
    int hit = -1;
    for (int i = 0; i < LETTER_COUNT; i++) if (legacy_code(src_enc, i) == {8'h00, b}) hit = i;
    return hit;
  endfunction

  function automatic int narrow_letter(logic [7:0] b);
    int hit = -1;
    for (int i = 0; i < LETTER_COUNT; i++)
      if (((src_enc == ENC_VPS) ? ROM_VPS[i] : ROM_VISCII[i]) == b) hit = i;
    return hit;
  endfunction

  function automatic void push_byte(logic [7:0] b, logic v, logic e);
    beat_t r;
    if (step_out.size() >= 6) return;
    r.data = v ? b : 8'h00;
    r.bval = v; r.last = 0; r.done = 0; r.err = e;
    step_out.push_back(r);
  endfunction

  function automatic void spell_letter(int idx);
    logic [23:0] u;
    logic [15:0] l;
    case (tgt_enc)
      ENC_UTF8: begin
        u = ROM_UTF8[idx];
        if (u > 24'hFFFF) push_byte(u[23:16], 1, 0);
        push_byte(u[15:8], 1, 0);
        push_byte(u[7:0], 1, 0);
      end
      ENC_VNI, ENC_TCVN3: begin
        l = legacy_code(tgt_enc, idx);
        if (l > 16'hFF) push_byte(l[15:8], 1, 0);
        push_byte(l[7:0], 1, 0);
      end
      ENC_VPS: push_byte(ROM_VPS[idx], 1, 0);
      default: push_byte(ROM_VISCII[idx], 1, 0);
    endcase
  endfunction

  function automatic bit legacy_alone(logic [7:0] h);
    int idx;
    if (h < 8'h80) begin
      push_byte(h, 1, 0);
      return 1;
    end
    idx = legacy_single(h);
    if (idx < 0) return 0;
    spell_letter(idx);
    return 1;
  endfunction

  // Transcode one accepted byte; results go to expected_q
  function automatic void transcode(logic [7:0] b, logic eos);
    bit err = 0;
    int idx;
    logic [23:0] v;
    step_out.delete();
    if (dropping) begin
    end else if (src_enc == tgt_enc || src_enc > ENC_TCVN3 || tgt_enc > ENC_TCVN3) begin
      push_byte(b, 1, 0);
    end else if (src_enc == ENC_UTF8) begin
      if (held_n == 0) begin
        if (b < 8'h80) push_byte(b, 1, 0);
        else begin held = {8'h00, b}; held_n = 1; end
      end else if (held_n == 1) begin
        v = {8'h00, held[7:0], b};
        idx = utf8_letter(v);
        if (idx >= 0) begin spell_letter(idx); held = 0; held_n = 0; end
        else begin held = v[15:0]; held_n = 2; end
      end else begin
        v = {held, b};
        idx = utf8_letter(v);
        if (idx >= 0) spell_letter(idx); else err = 1;
        held = 0; held_n = 0;
      end
    end else if (src_enc == ENC_VPS || src_enc == ENC_VISCII) begin
      if (b < 8'h80) push_byte(b, 1, 0);
      else begin
        idx = narrow_letter(b);
        if (idx >= 0) spell_letter(idx); else err = 1;
      end
    end else begin
      if (held_n == 0) begin
        held = {8'h00, b}; held_n = 1;
      end else begin
        idx = legacy_pair({held[7:0], b});
        if (idx >= 0) begin spell_letter(idx); held = 0; held_n = 0; end
        else if (!legacy_alone(held[7:0])) err = 1;
        else begin held = {8'h00, b}; held_n = 1; end
      end
      if (eos && !err && held_n != 0) void'(legacy_alone(held[7:0]));
    end
    if (err) begin
      push_byte(0, 0, 1);
      held = 0; held_n = 0; dropping = 1;
    end
    if (eos) begin
      held = 0; held_n = 0; dropping = 0;
      if (step_out.size() == 0) push_byte(0, 0, 0);
    end
    if (step_out.size() > 0) begin
      step_out[step_out.size()-1].last = 1;
      if (eos) step_out[step_out.size()-1].done = 1;
    end
    foreach (step_out[i]) expected_q.push_back(step_out[i]);
  endfunction

  // Input acceptance, seen at the rising edge
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o;
  end

  // Driver: a beat is held until accepted; config beats are written on their own
  always @(negedge clk_i) begin
    bit busy, vld_nx, we_nx;
    if (rst_ni) begin
      busy   = in_valid_i && !in_taken;
      vld_nx = busy;
      we_nx  = 0;
      if (!busy && pending_q.size() > 0) begin
        if (pending_q[0].cfg) begin
          // only once idle: nothing pending at the output and no beat waiting
          if (expected_q.size() == 0) begin
            we_nx       = 1;
            cfg_idx_i   <= pending_q[0].ridx;
            cfg_wdata_i <= pending_q[0].rval;
            if (pending_q[0].ridx == REG_SOURCE) src_enc = pending_q[0].rval;
            else tgt_enc = pending_q[0].rval;
            held = 0; held_n = 0; dropping = 0;
            void'(pending_q.pop_front());
          end
        end else if ($urandom_range(99) >= src_idle_pct) begin
          vld_nx             = 1;
          in_byte_i          <= pending_q[0].data;
          in_end_of_stream_i <= pending_q[0].eos;
          void'(pending_q.pop_front());
        end
      end
      in_valid_i  <= vld_nx;
      cfg_we_i    <= we_nx;
      out_stall_i <= ($urandom_range(99) < snk_idle_pct);
    end
  end

  // Monitor: predict on accepted input beats, check accepted output beats
  always @(posedge clk_i) begin
    beat_t e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) transcode(in_byte_i, in_end_of_stream_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected beat byte=%h valid=%b err=%b", $time,
                   out_byte_o, out_byte_valid_o, out_error_flag_o);
          fails++;
        end else begin
          e = expected_q.pop_front();
          if (e.data !== out_byte_o || e.bval !== out_byte_valid_o ||
              e.last !== out_last_of_run_o || e.done !== out_stream_done_o ||
              e.err !== out_error_flag_o) begin
            $display("%0t: mismatch exp byte=%h v=%b l=%b d=%b e=%b got byte=%h v=%b l=%b d=%b e=%b",
                     $time, e.data, e.bval, e.last, e.done, e.err, out_byte_o,
                     out_byte_valid_o, out_last_of_run_o, out_stream_done_o, out_error_flag_o);
            fails++;
          end
        end
      end
    end
  end

  // Stimulus building blocks
  task automatic add_byte(logic [7:0] b, logic eos);
    stim_t s;
    s.data = b; s.eos = eos; s.cfg = 0; s.ridx = REG_SOURCE; s.rval = '0;
    pending_q.push_back(s);
  endtask

  task automatic add_cfg(logic [1:0] r, logic [2:0] v);
    stim_t s;
    s.data = '0; s.eos = 0; s.cfg = 1; s.ridx = r; s.rval = v;
    pending_q.push_back(s);
  endtask

  // Source spelling of one letter, random bytes elsewhere
  task automatic add_letter(logic [2:0] enc, int idx);
    logic [23:0] u;
    logic [15:0] l;
    case (enc)
      ENC_UTF8: begin
        u = ROM_UTF8[idx];
        if (u > 24'hFFFF) add_byte(u[23:16], 0);
        add_byte(u[15:8], 0); add_byte(u[7:0], 0);
      end
      ENC_VNI, ENC_TCVN3: begin
        l = legacy_code(enc, idx);
        if (l > 16'hFF) add_byte(l[15:8], 0);
        add_byte(l[7:0], 0);
      end
      ENC_VPS: add_byte(ROM_VPS[idx], 0);
      default: add_byte(ROM_VISCII[idx], 0);
    endcase
  endtask

  task automatic add_text(logic [2:0] enc, int len);
    int k;
    for (int i = 0; i < len; i++) begin
      k = $urandom_range(99);
      if (k < 60) add_letter(enc, int'($urandom_range(LETTER_COUNT - 1)));
      else if (k < 90) add_byte(8'($urandom_range(8'h7F)), 0);
      else add_byte(8'($urandom_range(255)), 0);
    end
    // stream end, sometimes on a truncated lead byte
    if ($urandom_range(3) == 0) add_byte(8'(8'hC3 + $urandom_range(1) * 8'h1E), 1);
    else add_byte(8'($urandom_range(255)), 1);
  endtask

  // Wait for a phase to drain fully, with tail cycles for in-flight beats
  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    logic [2:0] s, t;
    held = 0; held_n = 0; dropping = 0;
    src_enc = ENC_UTF8; tgt_enc = ENC_UTF8;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1;

    // Directed: UTF-8 to VNI; two- and three-byte letters, ASCII, extremes, error, truncation
    add_cfg(REG_SOURCE, ENC_UTF8); add_cfg(REG_TARGET, ENC_VNI);
    add_byte(8'hC3, 0); add_byte(8'h80, 0);
    add_byte(8'hE1, 0); add_byte(8'hBB, 0); add_byte(8'hB9, 0);
    add_byte(8'h00, 0); add_byte(8'h7F, 0);
    add_byte(8'hFF, 0); add_byte(8'h00, 0); add_byte(8'h41, 0);
    add_byte(8'h42, 1);
    add_byte(8'hE1, 0); add_byte(8'hBB, 1);
    add_byte(8'h41, 1);
    // VNI longest match with an ASCII lead, then TCVN3 pair, register codes above four
    add_cfg(REG_SOURCE, ENC_VNI); add_cfg(REG_TARGET, ENC_UTF8);
    add_byte(8'h41, 0); add_byte(8'hD8, 0); add_byte(8'hD4, 0); add_byte(8'hD9, 1);
    add_cfg(REG_SOURCE, ENC_TCVN3);
    add_byte(8'hA2, 0); add_byte(8'hCA, 0); add_byte(8'hA2, 1);
    add_cfg(REG_SOURCE, 3'd7);
    add_byte(8'hFF, 0); add_byte(8'h80, 1);
    drain();

    // Random phases over encoding pairs, extremes included
    for (int ph = 0; ph < 30; ph++) begin
      if (ph == 10) begin src_idle_pct = 24; snk_idle_pct = 76; end
      if (ph == 20) begin src_idle_pct = 76; snk_idle_pct = 24; end
      if (ph == 27) begin src_idle_pct = 0; snk_idle_pct = 0; end
      s = 3'($urandom_range(4));
      t = 3'($urandom_range(4));
      if (ph == 0) begin s = ENC_TCVN3; t = ENC_TCVN3; end
      if (ph == 1) begin s = 3'd7; t = ENC_UTF8; end
      add_cfg(REG_SOURCE, s); add_cfg(REG_TARGET, t);
      for (int k = 0; k < 2; k++) add_text((s > ENC_TCVN3) ? ENC_UTF8 : s, $urandom_range(1, 3));
      drain();
    end
    if (fails == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_top: FAIL");
    $finish;
  end
endmodule

[vietnamese_charset_transcoder_unit.f]
rtl/vct_pkg.sv
rtl/vietnamese_charset_transcoder_unit.sv
rtl/vct_checker.sv
tb/sv/tb_top.sv
